>>> hw/rtl/gbb_pkg.sv
// Shared types, opcode constants and counter arithmetic for the gshare/BTB predictor.
// No dependencies.
`default_nettype none

package gbb_pkg;

	typedef logic [1:0] ctr_t;

	typedef struct packed {
		logic        valid;
		logic        cond;
		logic [63:0] tag;
		logic [63:0] target;
	} btb_entry_t;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	localparam logic [10:0] OPC_COND_B4   = 11'h0B4;
	localparam logic [10:0] OPC_COND_B5   = 11'h0B5;
	localparam logic [10:0] OPC_COND_54   = 11'h054;
	localparam logic [10:0] OPC_UNCOND_05 = 11'h005;
	localparam logic [10:0] OPC_UNCOND_6B = 11'h6B0;

	localparam ctr_t CTR_STRONG_NT = 2'd0;
	localparam ctr_t CTR_WEAK_T    = 2'd2;
	localparam ctr_t CTR_STRONG_T  = 2'd3;

	localparam logic [63:0] PC_STEP = 64'd4;

	function automatic logic is_cond(input logic [10:0] opc);
		return (opc == OPC_COND_B4) || (opc == OPC_COND_B5) || (opc == OPC_COND_54);
	endfunction

	function automatic logic is_uncond(input logic [10:0] opc);
		return (opc == OPC_UNCOND_05) || (opc == OPC_UNCOND_6B);
	endfunction

	// saturating two-bit train
	function automatic ctr_t ctr_train(input ctr_t c, input logic tk);
		ctr_t r;
		r = c;
		if (tk) begin
			if (c != CTR_STRONG_T) r = c + 2'd1;
		end else begin
			if (c != CTR_STRONG_NT) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gshare_btb_branch_predictor.sv
// gshare predictor with direct-mapped BTB. On acceptance of a word the counter and BTB
// RAMs are read into their registers and the word moves to the lookup state, which
// resolves it: a predict result is loaded into the output register once that register is
// free, an update word writes back to the RAMs. No new word is taken until the last one
// is resolved. After reset a clearing pass zeroes both RAMs; in_stall stays high until
// it ends.
`default_nettype none

module gshare_btb_branch_predictor #(
	parameter int HISTORY_BITS    = 8,
	parameter int COUNTER_ENTRIES = 256,
	parameter int TARGET_ENTRIES  = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [63:0] pc,
	input  wire logic [63:0] actual_target,
	input  wire logic        taken,
	input  wire logic [10:0] opcode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      next_pc,
	output logic             btb_miss
);
	import gbb_pkg::*;

	localparam int CW   = $clog2(COUNTER_ENTRIES);
	localparam int TW   = $clog2(TARGET_ENTRIES);
	localparam int XW   = (HISTORY_BITS > CW) ? HISTORY_BITS : CW;
	localparam int MAXE = (COUNTER_ENTRIES > TARGET_ENTRIES) ? COUNTER_ENTRIES : TARGET_ENTRIES;
	localparam int KW   = $clog2(MAXE) + 1;
	localparam logic [KW-1:0] CLR_LAST = KW'(MAXE - 1);
	localparam logic [KW-1:0] CLR_CTR  = KW'(COUNTER_ENTRIES);
	localparam logic [KW-1:0] CLR_TGT  = KW'(TARGET_ENTRIES);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

	state_t                  state_q;
	logic [KW-1:0]           clr_idx_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic                    out_valid_q;
	logic [63:0]             next_pc_q;
	logic                    btb_miss_q;

	logic          op_s1;
	logic [63:0]   pc_s1;
	logic [63:0]   actual_s1;
	logic          taken_s1;
	logic [10:0]   opcode_s1;
	logic [CW-1:0] cidx_s1;

	logic          accept;
	logic [XW-1:0] hx;
	logic [CW-1:0] cidx;
	ctr_t          ctr_rd;
	btb_entry_t    ent_rd;
	logic          hit;
	logic          out_free;
	logic          res_load;
	logic          upd_br;
	logic          upd_cond;

	logic          pht_we;
	logic [CW-1:0] pht_wa;
	ctr_t          pht_wd;
	logic          btb_we;
	logic [TW-1:0] btb_wa;
	btb_entry_t    btb_wd;
	logic [63:0]   pc_inc;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign res_load = (state_q == ST_LOOKUP) && (op_s1 == OP_PREDICT) && out_free;

	assign hx   = XW'(hist_q) ^ XW'(pc[CW+1:2]);
	assign cidx = hx[CW-1:0];

	assign upd_cond = is_cond(opcode_s1);
	assign upd_br   = upd_cond || is_uncond(opcode_s1);
	assign pc_inc   = pc_s1 + PC_STEP;

	gbb_pht #(.ENTRIES(COUNTER_ENTRIES)) u_pht (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (cidx),
		.rd_data (ctr_rd),
		.wr_en   (pht_we),
		.wr_addr (pht_wa),
		.wr_data (pht_wd)
	);

	gbb_btb #(.ENTRIES(TARGET_ENTRIES)) u_btb (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (pc[TW+1:2]),
		.cmp_pc   (pc_s1),
		.rd_entry (ent_rd),
		.hit      (hit),
		.wr_en    (btb_we),
		.wr_addr  (btb_wa),
		.wr_entry (btb_wd)
	);

	// write ports: clearing pass, else write-back of an update word
	always_comb begin
		pht_we = 1'b0;
		pht_wa = cidx_s1;
		pht_wd = ctr_train(ctr_rd, taken_s1);
		btb_we = 1'b0;
		btb_wa = pc_s1[TW+1:2];
		btb_wd.valid  = 1'b1;
		btb_wd.cond   = upd_cond;
		btb_wd.tag    = pc_s1;
		btb_wd.target = taken_s1 ? actual_s1 : (ent_rd.valid ? ent_rd.target : pc_inc);
		unique case (state_q)
			ST_CLEAR: begin
				pht_we = (clr_idx_q < CLR_CTR);
				pht_wa = clr_idx_q[CW-1:0];
				pht_wd = CTR_STRONG_NT;
				btb_we = (clr_idx_q < CLR_TGT);
				btb_wa = clr_idx_q[TW-1:0];
				btb_wd = '0;
			end
			ST_LOOKUP: begin
				pht_we = (op_s1 == OP_UPDATE) && upd_cond;
				btb_we = (op_s1 == OP_UPDATE) && upd_br;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			pc_s1     <= pc;
			actual_s1 <= actual_target;
			taken_s1  <= taken;
			opcode_s1 <= opcode;
			cidx_s1   <= cidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			hist_q      <= '0;
			out_valid_q <= 1'b0;
			next_pc_q   <= '0;
			btb_miss_q  <= 1'b0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + KW'(1);
					if (clr_idx_q == CLR_LAST) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (op_s1 == OP_PREDICT) begin
						// hold the read data until the output register is free
						if (out_free) begin
							btb_miss_q  <= !hit;
							next_pc_q   <= (hit && (!ent_rd.cond || ctr_rd >= CTR_WEAK_T))
								? ent_rd.target : pc_inc;
							state_q     <= ST_IDLE;
						end
					end else begin
						if (upd_cond) hist_q <= {hist_q[HISTORY_BITS-2:0], taken_s1};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc   = next_pc_q;
	assign btb_miss  = btb_miss_q;

endmodule

`default_nettype wire

>>> hw/rtl/gbb_pht.sv
// Pattern history table: synchronous RAM of two-bit counters, registered read.
// Depends on gbb_pkg.
`default_nettype none

module gbb_pht #(
	parameter int ENTRIES = 256,
	localparam int AW = $clog2(ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output gbb_pkg::ctr_t      rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire gbb_pkg::ctr_t wr_data
);
	import gbb_pkg::*;

	ctr_t mem_q [ENTRIES];
	ctr_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/gbb_btb.sv
// Direct-mapped branch target buffer: entry RAM with registered read and tag compare.
// Depends on gbb_pkg.
`default_nettype none

module gbb_btb #(
	parameter int ENTRIES = 1024,
	localparam int AW = $clog2(ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic [63:0]   cmp_pc,
	output gbb_pkg::btb_entry_t rd_entry,
	output logic               hit,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire gbb_pkg::btb_entry_t wr_entry
);
	import gbb_pkg::*;

	btb_entry_t mem_q [ENTRIES];
	btb_entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_entry;
		if (rd_en) rd_entry_q <= mem_q[rd_addr];
	end

	assign rd_entry = rd_entry_q;
	assign hit      = rd_entry_q.valid && (rd_entry_q.tag == cmp_pc);

endmodule

`default_nettype wire
